/* src/gls_pkg.sv */
`default_nettype none

package gls_pkg;

   // Map geometry
   localparam int MAP_W  = 256;
   localparam int MAP_H  = 64;
   localparam int DEPTH  = MAP_W * MAP_H;
   localparam int ADDR_W = $clog2(DEPTH);

   // Coordinate and arithmetic widths
   localparam int X_W    = 8;
   localparam int Y_W    = 6;
   localparam int PROD_W = X_W + Y_W;
   localparam int FRAC_W = PROD_W + 3;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   // Cell write toward the map
   typedef struct packed {
      logic           en;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic           val;
   } map_wr_type;

   // Cell read address toward the map
   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
   } map_rd_type;

   // Map status back to the sequencer
   typedef struct packed {
      logic busy;
      logic open;
   } map_stat_type;

endpackage

`default_nettype wire

/* src/gls_if.sv */
`default_nettype none

interface gls_req_if import gls_pkg::*; ();
   logic           valid;
   logic           ready;
   logic           opcode;
   logic [X_W-1:0] start_x;
   logic [Y_W-1:0] start_y;
   logic [X_W-1:0] end_x;
   logic [Y_W-1:0] end_y;
   logic           passable;

   modport source (
      output valid, opcode, start_x, start_y, end_x, end_y, passable,
      input  ready
   );
   modport sink (
      input  valid, opcode, start_x, start_y, end_x, end_y, passable,
      output ready
   );
endinterface

interface gls_rsp_if ();
   logic valid;
   logic ready;
   logic visible;

   modport source (
      output valid, visible,
      input  ready
   );
   modport sink (
      input  valid, visible,
      output ready
   );
endinterface

`default_nettype wire

/* src/grid_line_of_sight_unit.sv */
`default_nettype none

// Line-of-sight unit over a one-bit passability map of MAP_W x MAP_H cells.
// req_ch carries one item per transfer: a cell write (opcode OP_WRITE) that
// stores 'passable' at (start_x, start_y), or a query (OP_QUERY) that asks
// whether sight runs from the start cell to the end cell. Writes give no
// result and leave req_ch ready. Each query gives one transfer on rsp_ch
// with the 'visible' bit, after a small sequencer around one shared 8x6
// multiplier and one fraction adder. Identical or touching cells are visible
// without a walk; a knight move passes through an open neighbor and else
// falls back to a slanted walk; other queries walk a straight row or column
// or a slanted line. A walk tests cells (map read, then check) up to the
// first blocked one, at most the longer span plus the minor span of them.
// req_ch is not ready while a query is in flight. The result sits in an
// output register, so a new item is taken while an earlier result waits; a
// finished query holds in its last state until the output register is free.
// After reset the map is swept to all blocked, one cell a cycle; req_ch
// stays not ready during the sweep.
module grid_line_of_sight_unit import gls_pkg::*; (
   input wire        clock,
   input wire        reset,
   gls_req_if.sink   req_ch,
   gls_rsp_if.source rsp_ch
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SETUP     = 9'b000000010,
      ST_KNIGHT_RD = 9'b000000100,
      ST_KNIGHT_CK = 9'b000001000,
      ST_MUL_HALF  = 9'b000010000,
      ST_MUL_FRAC  = 9'b000100000,
      ST_WALK_RD   = 9'b001000000,
      ST_WALK_CK   = 9'b010000000,
      ST_DONE      = 9'b100000000
   } state_type;

   state_type                state_ff, state_in;
   logic [X_W-1:0]           x1_ff, x1_in, x2_ff, x2_in, cx_ff, cx_in;
   logic [Y_W-1:0]           y1_ff, y1_in, y2_ff, y2_in, cy_ff, cy_in;
   logic [X_W-1:0]           ax_ff, ax_in;
   logic [Y_W-1:0]           ay_ff, ay_in;
   logic                     sxn_ff, sxn_in, syn_ff, syn_in;
   logic                     xmajor_ff, xmajor_in;
   logic                     straight_ff, straight_in;
   logic                     extra_ff, extra_in;
   logic [PROD_W-1:0]        half_ff, half_in;
   logic [PROD_W:0]          step_ff, step_in;
   logic signed [FRAC_W-1:0] frac_ff, frac_in;
   logic                     vis_ff, vis_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_visible_ff, rsp_visible_in;

   logic                     req_fire;
   logic                     map_busy;
   map_wr_type               map_wr;
   map_rd_type               map_rd;
   map_stat_type             map_stat;

   logic [X_W-1:0]           x1_fwd, cx_fwd;
   logic [Y_W-1:0]           y1_fwd, cy_fwd;
   logic [Y_W-1:0]           minor;
   logic [X_W-1:0]           mul_a;
   logic [Y_W-1:0]           mul_b;
   logic [PROD_W-1:0]        mul_p;
   logic signed [FRAC_W-1:0] half_s, full_s, frac_sum, frac_sub;
   logic                     major_end;

   // Cell map with its clearing sweep
   gls_map u_map (
      .clock (clock),
      .reset (reset),
      .wr    (map_wr),
      .rd    (map_rd),
      .stat  (map_stat)
   );

   assign map_busy      = map_stat.busy;
   assign req_ch.ready  = (state_ff == ST_IDLE) && !map_busy;
   assign req_fire      = req_ch.valid && req_ch.ready;

   assign map_wr.en     = req_fire && (req_ch.opcode == OP_WRITE);
   assign map_wr.x      = req_ch.start_x;
   assign map_wr.y      = req_ch.start_y;
   assign map_wr.val    = req_ch.passable;
   assign map_rd.x      = cx_ff;
   assign map_rd.y      = cy_ff;

   // One step toward the end cell on each axis
   assign x1_fwd = sxn_ff ? x1_ff - 1'b1 : x1_ff + 1'b1;
   assign y1_fwd = syn_ff ? y1_ff - 1'b1 : y1_ff + 1'b1;
   assign cx_fwd = sxn_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
   assign cy_fwd = syn_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
   assign major_end = xmajor_ff ? (cx_fwd == x2_ff) : (cy_fwd == y2_ff);

   // Shared multiplier: ax*ay, then minor span squared
   assign minor = xmajor_ff ? ay_ff : ax_ff[Y_W-1:0];
   assign mul_a = (state_ff == ST_MUL_FRAC) ? X_W'(minor) : ax_ff;
   assign mul_b = (state_ff == ST_MUL_FRAC) ? minor : ay_ff;
   assign mul_p = {{Y_W{1'b0}}, mul_a} * {{X_W{1'b0}}, mul_b};

   // Fraction adder for the walk
   assign half_s   = $signed(FRAC_W'(half_ff));
   assign full_s   = $signed(FRAC_W'({half_ff, 1'b0}));
   assign frac_sum = frac_ff + $signed(FRAC_W'(step_ff));
   assign frac_sub = frac_sum - full_s;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      x2_in          = x2_ff;
      y2_in          = y2_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      sxn_in         = sxn_ff;
      syn_in         = syn_ff;
      xmajor_in      = xmajor_ff;
      straight_in    = straight_ff;
      extra_in       = extra_ff;
      half_in        = half_ff;
      step_in        = step_ff;
      frac_in        = frac_ff;
      vis_in         = vis_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_visible_in = rsp_visible_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Latch a query and its spans
            if (req_fire && (req_ch.opcode == OP_QUERY)) begin
               x1_in  = req_ch.start_x;
               y1_in  = req_ch.start_y;
               x2_in  = req_ch.end_x;
               y2_in  = req_ch.end_y;
               sxn_in = req_ch.end_x < req_ch.start_x;
               syn_in = req_ch.end_y < req_ch.start_y;
               ax_in  = sxn_in ? req_ch.start_x - req_ch.end_x
                               : req_ch.end_x - req_ch.start_x;
               ay_in  = syn_in ? req_ch.start_y - req_ch.end_y
                               : req_ch.end_y - req_ch.start_y;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Sort out near cells, straight lines and knight moves
            extra_in    = 1'b0;
            straight_in = 1'b0;
            if (ax_ff[X_W-1:1] == '0 && ay_ff[Y_W-1:1] == '0) begin
               vis_in   = 1'b1;
               state_in = ST_DONE;
            end else if (ax_ff == '0) begin
               straight_in = 1'b1;
               xmajor_in   = 1'b0;
               cx_in       = x1_ff;
               cy_in       = y1_fwd;
               state_in    = ST_WALK_RD;
            end else if (ay_ff == '0) begin
               straight_in = 1'b1;
               xmajor_in   = 1'b1;
               cx_in       = x1_fwd;
               cy_in       = y1_ff;
               state_in    = ST_WALK_RD;
            end else if (ax_ff == X_W'(1) && ay_ff == Y_W'(2)) begin
               cx_in    = x1_ff;
               cy_in    = y1_fwd;
               state_in = ST_KNIGHT_RD;
            end else if (ax_ff == X_W'(2) && ay_ff == Y_W'(1)) begin
               cx_in    = x1_fwd;
               cy_in    = y1_ff;
               state_in = ST_KNIGHT_RD;
            end else begin
               state_in = ST_MUL_HALF;
            end
         end
         ST_KNIGHT_RD: begin
            state_in = ST_KNIGHT_CK;
         end
         ST_KNIGHT_CK: begin
            // Open orthogonal cell passes the knight move at once
            if (map_stat.open) begin
               vis_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_HALF;
            end
         end
         ST_MUL_HALF: begin
            half_in   = mul_p;
            xmajor_in = ax_ff >= X_W'(ay_ff);
            state_in  = ST_MUL_FRAC;
         end
         ST_MUL_FRAC: begin
            // Seed the fraction and the first entered cell
            step_in = {mul_p, 1'b0};
            if (ax_ff == X_W'(ay_ff)) begin
               frac_in = -half_s;
               cx_in   = x1_fwd;
               cy_in   = y1_fwd;
            end else begin
               frac_in = $signed(FRAC_W'(mul_p));
               cx_in   = xmajor_ff ? x1_fwd : x1_ff;
               cy_in   = xmajor_ff ? y1_ff : y1_fwd;
            end
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CK;
         end
         ST_WALK_CK: begin
            if (!map_stat.open) begin
               // Drop out at the first blocked cell
               vis_in   = 1'b0;
               state_in = ST_DONE;
            end else if (!straight_ff && !extra_ff && (frac_sum > half_s)) begin
               // Cross into the next minor line; test that cell before advancing
               frac_in  = frac_sub;
               extra_in = 1'b1;
               if (xmajor_ff) begin
                  cy_in = cy_fwd;
               end else begin
                  cx_in = cx_fwd;
               end
               state_in = ST_WALK_RD;
            end else begin
               // Advance along the major axis, brushing a corner if exactly on it
               extra_in = 1'b0;
               if (!straight_ff && !extra_ff) begin
                  if (frac_sum == half_s) begin
                     frac_in = frac_sub;
                     if (xmajor_ff) begin
                        cy_in = cy_fwd;
                     end else begin
                        cx_in = cx_fwd;
                     end
                  end else begin
                     frac_in = frac_sum;
                  end
               end
               if (xmajor_ff) begin
                  cx_in = cx_fwd;
               end else begin
                  cy_in = cy_fwd;
               end
               if (major_end) begin
                  vis_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = vis_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      x2_ff          <= x2_in;
      y2_ff          <= y2_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      sxn_ff         <= sxn_in;
      syn_ff         <= syn_in;
      xmajor_ff      <= xmajor_in;
      straight_ff    <= straight_in;
      extra_ff       <= extra_in;
      half_ff        <= half_in;
      step_ff        <= step_in;
      frac_ff        <= frac_in;
      vis_ff         <= vis_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.visible = rsp_visible_ff;

endmodule

`default_nettype wire

/* src/gls_map.sv */
`default_nettype none

module gls_map import gls_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  map_wr_type   wr,
   input  map_rd_type   rd,
   output map_stat_type stat
);

   logic              map_mem [DEPTH];
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_busy_ff, clr_busy_in;
   logic              rd_bit_ff;
   logic              rd_inmap_ff;
   logic [ADDR_W-1:0] waddr, raddr;
   logic              wr_inmap, rd_inmap;

   // Map coordinates to a linear address, flag cells outside the map
   assign waddr    = ADDR_W'(ADDR_W'(wr.y) * ADDR_W'(MAP_W)) + ADDR_W'(wr.x);
   assign raddr    = ADDR_W'(ADDR_W'(rd.y) * ADDR_W'(MAP_W)) + ADDR_W'(rd.x);
   assign wr_inmap = (32'(wr.x) < MAP_W) && (32'(wr.y) < MAP_H);
   assign rd_inmap = (32'(rd.x) < MAP_W) && (32'(rd.y) < MAP_H);

   // Sweep every cell to blocked after reset
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Map storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         map_mem[clr_cnt_ff] <= 1'b0;
      end else if (wr.en && wr_inmap) begin
         map_mem[waddr] <= wr.val;
      end
      rd_bit_ff   <= map_mem[raddr];
      rd_inmap_ff <= rd_inmap;
   end

   assign stat.busy = clr_busy_ff;
   assign stat.open = rd_bit_ff & rd_inmap_ff;

endmodule

`default_nettype wire
